// ===== sv/rti_pkg.sv =====
// Shared constants, register codes and arithmetic helpers for the ray/triangle test.
package rti_pkg;

  // Fractional bits of the coordinate format
  localparam int FRAC = 16;
  localparam int PW = 64 - FRAC;          // width of a shifted 32x32 product
  localparam int DOTW = PW + 2;           // width of a three-term dot product
  localparam int DW = DOTW;               // divider operand width
  localparam int QBITS = 32;              // quotient bits produced by the divider
  localparam int DIV_LAT = QBITS + 1;     // length of the divider pipeline in registers
  localparam int UW = 17;                 // barycentric output width
  localparam int IN_W = 9 * 32;
  localparam int OUT_W = 72;

  localparam logic [31:0] Q_MAX = 32'h8000_0000;
  localparam logic [31:0] T_POS_MAX = 32'h7FFF_FFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_CULL = 3'd6;
  localparam logic [2:0] REG_EPS = 3'd7;

  // Saturating 32-bit difference
  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return d[31:0];
  endfunction

  // Product shifted right by FRAC with floor rounding
  function automatic logic signed [PW-1:0] mulq(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:FRAC];
  endfunction

  // Saturate a product difference to 32 bits
  function automatic logic signed [31:0] sat_pw(logic signed [PW:0] x);
    logic signed [PW:0] hi;
    logic signed [PW:0] lo;
    hi = (PW+1)'(33'sh0_7FFF_FFFF);
    lo = -hi - (PW+1)'(1);
    if (x > hi) return 32'sh7FFF_FFFF;
    if (x < lo) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

// ===== sv/rti_divider.sv =====
// Pipelined restoring divider: (num << FRAC) / den, one quotient bit per stage, saturated.
module rti_divider (
  input  logic                   clk,
  input  logic                   en,
  input  logic [rti_pkg::DW-1:0] num,
  input  logic [rti_pkg::DW-1:0] den,
  output logic [31:0]            quo
);
  import rti_pkg::*;

  localparam int NW = DW + FRAC;

  logic [NW-1:0] dividend;
  logic [NW-1:0] hi_ext;
  logic          ovf0;

  logic [DW-1:0] rem [0:QBITS];
  logic [31:0]   low [0:QBITS];
  logic [31:0]   q   [0:QBITS];
  logic [DW-1:0] dn  [0:QBITS];
  logic          ovf [0:QBITS];

  // the shifted numerator keeps only its low 64 bits
  assign dividend = {{(NW-64){1'b0}}, num[63-FRAC:0], {FRAC{1'b0}}};
  assign hi_ext = dividend >> QBITS;
  // quotient would not fit in QBITS bits
  assign ovf0 = hi_ext >= NW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi_ext[DW-1:0];
      low[0] <= dividend[31:0];
      q[0]   <= '0;
      dn[0]  <= den;
      ovf[0] <= ovf0;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem[k], low[k][31]};
    assign diff = trial - {1'b0, dn[k]};
    assign ge = trial >= {1'b0, dn[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[k+1] <= {low[k][30:0], 1'b0};
        q[k+1]   <= {q[k][30:0], ge};
        dn[k+1]  <= dn[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  assign quo = (ovf[QBITS] || q[QBITS] > Q_MAX) ? Q_MAX : q[QBITS];

endmodule

// ===== sv/ray_triangle_intersect_unit.sv =====
// Top level of the pipelined Moller-Trumbore ray/triangle intersection unit.
// One triangle word enters per cycle and one result word leaves per cycle while the
// output is not held. Each passes seven arithmetic stages (edges, cross multiply,
// cross saturate, dot multiply, sums, determinant test, range test), the 33-stage
// bit-per-stage divider and the output register. The whole pipeline advances
// together whenever the output register is empty or being taken, so s_tready drops
// only while a result waits and m_tready is low. The ray lives in the configuration
// registers; write them only while idle. Values are signed Q16.16. A miss gives
// hit=0 with t, u and v at zero; t saturates.
module ray_triangle_intersect_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, 32 bits each, low first
  input  logic [rti_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // hit[0], hit_distance[32:1], bary_u[49:33], bary_v[66:50], zero fill [71:67]
  output logic [rti_pkg::OUT_W-1:0]  m_tdata,
  input  logic                       cfg_wr_en,
  input  logic [2:0]                 cfg_addr,
  input  logic [31:0]                cfg_wdata
);
  import rti_pkg::*;

  localparam int NV = 7 + DIV_LAT;

  // configuration
  logic signed [31:0] orig [3];
  logic signed [31:0] dir  [3];
  logic               cull;
  logic [15:0]        eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      orig[0] <= '0; orig[1] <= '0; orig[2] <= '0;
      dir[0] <= '0; dir[1] <= '0; dir[2] <= 32'sh0001_0000;
      cull <= 1'b1;
      eps <= 16'd16;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ORIGIN_X: orig[0] <= cfg_wdata;
        REG_ORIGIN_Y: orig[1] <= cfg_wdata;
        REG_ORIGIN_Z: orig[2] <= cfg_wdata;
        REG_DIR_X: dir[0] <= cfg_wdata;
        REG_DIR_Y: dir[1] <= cfg_wdata;
        REG_DIR_Z: dir[2] <= cfg_wdata;
        REG_CULL: cull <= cfg_wdata[0];
        REG_EPS: eps <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // advance everything when the output slot is free or being drained
  logic en;
  logic [NV-1:0] vs;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[NV-2:0], s_tvalid};
    end
  end

  // stage 1: edges and origin offset
  logic signed [31:0] vin [9];
  logic signed [31:0] e1 [3], e2 [3], tv [3];
  always_comb begin
    for (int i = 0; i < 9; i++) vin[i] = s_tdata[32*i +: 32];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= sat_sub(vin[3+i], vin[i]);
        e2[i] <= sat_sub(vin[6+i], vin[i]);
        tv[i] <= sat_sub(orig[i], vin[i]);
      end
    end
  end

  // stage 2: cross product terms, pvec = dir x e2, qvec = tv x e1
  logic signed [PW-1:0] pa [3], pb [3], qa [3], qb [3];
  logic signed [31:0] e1_2 [3], e2_2 [3], tv_2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= mulq(dir[(i+1)%3], e2[(i+2)%3]);
        pb[i] <= mulq(dir[(i+2)%3], e2[(i+1)%3]);
        qa[i] <= mulq(tv[(i+1)%3], e1[(i+2)%3]);
        qb[i] <= mulq(tv[(i+2)%3], e1[(i+1)%3]);
      end
      e1_2 <= e1; e2_2 <= e2; tv_2 <= tv;
    end
  end

  // stage 3: saturate cross products
  logic signed [31:0] pv [3], qv [3];
  logic signed [31:0] e1_3 [3], e2_3 [3], tv_3 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pv[i] <= sat_pw({pa[i][PW-1], pa[i]} - {pb[i][PW-1], pb[i]});
        qv[i] <= sat_pw({qa[i][PW-1], qa[i]} - {qb[i][PW-1], qb[i]});
      end
      e1_3 <= e1_2; e2_3 <= e2_2; tv_3 <= tv_2;
    end
  end

  // stage 4: dot product terms
  logic signed [PW-1:0] dp [3], up [3], vp [3], tp [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp[i] <= mulq(e1_3[i], pv[i]);
        up[i] <= mulq(tv_3[i], pv[i]);
        vp[i] <= mulq(dir[i], qv[i]);
        tp[i] <= mulq(e2_3[i], qv[i]);
      end
    end
  end

  // stage 5: sum the terms exactly
  logic signed [DOTW-1:0] det5, un5, vn5, tn5;
  always_ff @(posedge clk) begin
    if (en) begin
      det5 <= DOTW'(dp[0]) + DOTW'(dp[1]) + DOTW'(dp[2]);
      un5  <= DOTW'(up[0]) + DOTW'(up[1]) + DOTW'(up[2]);
      vn5  <= DOTW'(vp[0]) + DOTW'(vp[1]) + DOTW'(vp[2]);
      tn5  <= DOTW'(tp[0]) + DOTW'(tp[1]) + DOTW'(tp[2]);
    end
  end

  // stage 6: determinant threshold, fold the sign into the numerators
  logic signed [DOTW-1:0] eps_s, det_abs;
  logic det_ok;
  logic ok6;
  logic signed [DOTW-1:0] det6, un6, vn6, tn6;
  assign eps_s = DOTW'({1'b0, eps});
  assign det_abs = det5[DOTW-1] ? -det5 : det5;
  assign det_ok = (det5 != '0) && (cull ? (det5 >= eps_s) : (det_abs >= eps_s));
  always_ff @(posedge clk) begin
    if (en) begin
      ok6  <= det_ok;
      det6 <= det_abs;
      un6  <= det5[DOTW-1] ? -un5 : un5;
      vn6  <= det5[DOTW-1] ? -vn5 : vn5;
      tn6  <= det5[DOTW-1] ? -tn5 : tn5;
    end
  end

  // stage 7: barycentric range checks, magnitudes for the dividers
  logic signed [DOTW:0] uv_sum;
  logic hit7, tneg7;
  logic [DW-1:0] den7, tmag7, umag7, vmag7;
  assign uv_sum = {un6[DOTW-1], un6} + {vn6[DOTW-1], vn6};
  always_ff @(posedge clk) begin
    if (en) begin
      hit7  <= ok6 && !un6[DOTW-1] && (un6 <= det6) && !vn6[DOTW-1]
               && (uv_sum <= {1'b0, det6});
      tneg7 <= tn6[DOTW-1];
      den7  <= det6;
      tmag7 <= tn6[DOTW-1] ? -tn6 : tn6;
      umag7 <= un6;
      vmag7 <= vn6;
    end
  end

  // dividers and the side band that travels beside them
  logic [31:0] quo_t, quo_u, quo_v;
  logic [DIV_LAT-1:0] hit_d, tneg_d;

  rti_divider u_div_t (.clk(clk), .en(en), .num(tmag7), .den(den7), .quo(quo_t));
  rti_divider u_div_u (.clk(clk), .en(en), .num(umag7), .den(den7), .quo(quo_u));
  rti_divider u_div_v (.clk(clk), .en(en), .num(vmag7), .den(den7), .quo(quo_v));

  always_ff @(posedge clk) begin
    if (en) begin
      hit_d  <= {hit_d[DIV_LAT-2:0], hit7};
      tneg_d <= {tneg_d[DIV_LAT-2:0], tneg7};
    end
  end

  // output register: apply sign and saturation, zero the fields on a miss
  logic        hit_o;
  logic [31:0] t_o;
  logic [OUT_W-1:0] word_next;
  assign hit_o = hit_d[DIV_LAT-1];
  assign t_o = tneg_d[DIV_LAT-1] ? -quo_t : ((quo_t == Q_MAX) ? T_POS_MAX : quo_t);
  always_comb begin
    word_next = '0;
    if (hit_o) begin
      word_next[0] = 1'b1;
      word_next[32:1] = t_o;
      word_next[33 +: UW] = quo_u[UW-1:0];
      word_next[33+UW +: UW] = quo_v[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vs[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= word_next;
    end
  end

  // a miss carries no distance or coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
    else $error("miss word has nonzero fields");

  // floor(u) + floor(v) never exceeds one on a hit
  a_bary_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      ({1'b0, m_tdata[33 +: UW]} + {1'b0, m_tdata[33+UW +: UW]}) <= (UW+1)'(1 << FRAC))
    else $error("barycentric sum out of range");

  // a held result freezes the valid pipeline
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(vs))
    else $error("pipeline moved during stall");

endmodule

// ===== sim/ray_triangle_intersect_unit_tb.sv =====
// Self-checking testbench for the ray/triangle intersection unit.
`timescale 1ns / 1ps

module ray_triangle_intersect_unit_tb;
  import rti_pkg::*;

  localparam longint ONE = 64'sd65536;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] hit_dist;
    logic [16:0] u;
    logic [16:0] v;
  } isect_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [2:0]          cfg_addr = REG_ORIGIN_X;
  logic [31:0]         cfg_wdata = '0;

  // Ray and mode as the block should currently hold them
  longint ray_org [3];
  longint ray_dir [3];
  bit     cull_on;
  longint eps_val;

  logic [IN_W-1:0] tri_q [$];   // triangles waiting to be offered
  isect_t          isect_q [$]; // predicted results, oldest first

  int  errors = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  hits_seen = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  no_idle = 1'b0;
  bit  hold_off_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  ray_triangle_intersect_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Intersection predictor: fixed-point Moller-Trumbore at 64-bit precision
  // ---------------------------------------------------------------------------
  function automatic longint clip32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // Product of two Q values, floor-shifted back to Q format
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic vec3_t cross_sat(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = clip32(qmul(a.y, b.z) - qmul(a.z, b.y));
    r.y = clip32(qmul(a.z, b.x) - qmul(a.x, b.z));
    r.z = clip32(qmul(a.x, b.y) - qmul(a.y, b.x));
    return r;
  endfunction

  function automatic longint dot_exact(vec3_t a, vec3_t b);
    return qmul(a.x, b.x) + qmul(a.y, b.y) + qmul(a.z, b.z);
  endfunction

  // (num << FRAC) / den for den > 0, truncated, magnitude capped at 2^31.
  // The shift wraps at 64 bits, matching the unsigned datapath.
  function automatic longint quot_q(longint num, longint den);
    bit [63:0] mag;
    bit [63:0] q;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    q = (mag << FRAC) / 64'(den);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint coord(logic [IN_W-1:0] d, int k);
    return longint'(signed'(d[32*k +: 32]));
  endfunction

  function automatic isect_t predict_isect(logic [IN_W-1:0] d);
    vec3_t  e1, e2, tv, dr, pv, qv;
    longint det, un, vn, tn;
    isect_t r;
    r = '0;
    e1 = '{clip32(coord(d, 3) - coord(d, 0)), clip32(coord(d, 4) - coord(d, 1)),
           clip32(coord(d, 5) - coord(d, 2))};
    e2 = '{clip32(coord(d, 6) - coord(d, 0)), clip32(coord(d, 7) - coord(d, 1)),
           clip32(coord(d, 8) - coord(d, 2))};
    tv = '{clip32(ray_org[0] - coord(d, 0)), clip32(ray_org[1] - coord(d, 1)),
           clip32(ray_org[2] - coord(d, 2))};
    dr = '{ray_dir[0], ray_dir[1], ray_dir[2]};
    pv = cross_sat(dr, e2);
    det = dot_exact(e1, pv);
    // zero determinant never hits, even with a zero threshold
    if (det == 0) return r;
    if (cull_on && det < eps_val) return r;
    if (!cull_on && ((det < 0) ? -det : det) < eps_val) return r;
    un = dot_exact(tv, pv);
    qv = cross_sat(tv, e1);
    vn = dot_exact(dr, qv);
    tn = dot_exact(e2, qv);
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    if (un < 0 || un > det) return r;
    if (vn < 0 || un + vn > det) return r;
    // t is not range checked: behind the origin still counts as a hit
    r.hit = 1'b1;
    r.hit_dist = 32'(clip32(quot_q(tn, det)));
    r.u = 17'(quot_q(un, det));
    r.v = 17'(quot_q(vn, det));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued triangles, hold a word until taken, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        isect_q.push_back(predict_isect(s_tdata));
        words_in++;
        gap_left = no_idle ? 0 :
                   (($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0);
      end
      if (s_tvalid && !s_tready) begin
        // hold the word until the block takes it
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (tri_q.size() > 0) begin
        s_tdata  <= tri_q.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, one long hold-off, field-by-field check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    isect_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[0], m_tdata[32:1], m_tdata[49:33], m_tdata[66:50]};
        words_out++;
        if (isect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        end else begin
          want = isect_q.pop_front();
          if (got.hit) hits_seen++;
          if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
          end
          if (got.hit_dist !== want.hit_dist) begin
            errors++;
            $display("%0t: hit_distance expected %h actual %h", $time, want.hit_dist,
                     got.hit_dist);
          end
          if (got.u !== want.u) begin
            errors++;
            $display("%0t: bary_u expected %h actual %h", $time, want.u, got.u);
          end
          if (got.v !== want.v) begin
            errors++;
            $display("%0t: bary_v expected %h actual %h", $time, want.v, got.v);
          end
        end
        stall_left = no_idle ? 0 :
                     (($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0);
      end
      // one long hold-off so the pipeline fills and stalls its input
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, longint value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= 32'(value);
    case (idx)
      REG_ORIGIN_X: ray_org[0] = longint'(signed'(32'(value)));
      REG_ORIGIN_Y: ray_org[1] = longint'(signed'(32'(value)));
      REG_ORIGIN_Z: ray_org[2] = longint'(signed'(32'(value)));
      REG_DIR_X:    ray_dir[0] = longint'(signed'(32'(value)));
      REG_DIR_Y:    ray_dir[1] = longint'(signed'(32'(value)));
      REG_DIR_Z:    ray_dir[2] = longint'(signed'(32'(value)));
      REG_CULL:     cull_on = value[0];
      REG_EPS:      eps_val = value & 64'hFFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz, longint dx, longint dy,
                         longint dz, bit cull, longint eps);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_CULL, cull);
    write_reg(REG_EPS, eps);
  endtask

  task automatic push_tri(longint a0, longint a1, longint a2, longint b0, longint b1,
                          longint b2, longint c0, longint c1, longint c2);
    tri_q.push_back({32'(c2), 32'(c1), 32'(c0), 32'(b2), 32'(b1), 32'(b0),
                     32'(a2), 32'(a1), 32'(a0)});
  endtask

  // Wait for every queued word to go through, then let the pipeline settle;
  // sample between edges so the driver's updates have landed
  task automatic drain();
    while (tri_q.size() > 0 || s_tvalid || isect_q.size() > 0) @(negedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic longint rnd_signed(int bits);
    longint m;
    m = longint'({$urandom, $urandom}) & ((64'sd1 << bits) - 1);
    return m - (64'sd1 << (bits - 1));
  endfunction

  // Triangle around a point on the ray, mostly in front of the origin
  task automatic push_near_ray(int spread);
    longint s, c [3], p [9];
    s = ($urandom_range(0, 5) == 0) ? -longint'($urandom_range(0, 1 << 18)) :
        longint'($urandom_range(0, 1 << 19));
    for (int k = 0; k < 3; k++) c[k] = ray_org[k] + qmul(ray_dir[k], s);
    for (int j = 0; j < 9; j++) p[j] = clip32(c[j % 3] + rnd_signed(spread));
    push_tri(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
  endtask

  task automatic push_random();
    case ($urandom_range(0, 2))
      0: push_tri(rnd_signed(32), rnd_signed(32), rnd_signed(32), rnd_signed(32),
                  rnd_signed(32), rnd_signed(32), rnd_signed(32), rnd_signed(32),
                  rnd_signed(32));
      1: push_tri(rnd_signed(20), rnd_signed(20), rnd_signed(20), rnd_signed(20),
                  rnd_signed(20), rnd_signed(20), rnd_signed(20), rnd_signed(20),
                  rnd_signed(20));
      default: begin
        // exact shared vertex: hits on the u or v boundary
        longint q [3];
        for (int k = 0; k < 3; k++) q[k] = clip32(ray_org[k] + qmul(ray_dir[k], 3 * ONE));
        push_tri(q[0], q[1], q[2], q[0] + rnd_signed(20), q[1] + rnd_signed(20), q[2],
                 q[0] + rnd_signed(20), q[1] + rnd_signed(20), q[2] + rnd_signed(12));
      end
    endcase
  endtask

  task automatic directed_set();
    // square-ish triangle across the z axis, both windings
    push_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE);
    push_tri(-ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE, ONE, -ONE, 5*ONE);
    // behind the origin: negative t
    push_tri(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, -ONE, ONE, -5*ONE);
    push_tri(-ONE, -ONE, -5*ONE, -ONE, ONE, -5*ONE, ONE, -ONE, -5*ONE);
    // ray through a vertex and through an edge midpoint, and one that misses beside an edge
    push_tri(0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE);
    push_tri(-ONE, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE);
    push_tri(ONE, 0, 2*ONE, 0, ONE, 2*ONE, ONE, ONE, 2*ONE);
    // triangle off to the side: barycentric miss
    push_tri(3*ONE, 3*ONE, ONE, 4*ONE, 3*ONE, ONE, 3*ONE, 4*ONE, ONE);
    // tiny triangle: determinant below the threshold
    push_tri(0, 0, ONE, 2, 0, ONE, 0, 2, ONE);
    push_tri(0, 0, ONE, 0, 2, ONE, 2, 0, ONE);
    // degenerate: zero determinant
    push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_tri(0, 0, ONE, ONE, 0, ONE, 2*ONE, 0, ONE);
    // triangle parallel to the ray
    push_tri(0, -ONE, 0, 0, ONE, 0, 0, 0, 4*ONE);
    // field extremes: saturated edges and cross products
    push_tri(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648,
             -64'sd2147483648, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
             64'sd2147483647);
    push_tri(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
             -64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
             64'sd2147483647);
    push_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1);
    push_tri(-64'sd2147483648, 0, ONE, 64'sd2147483647, 0, ONE, 0, 64'sd2147483647, ONE);
    // far plane: t near saturation
    push_tri(-ONE, -ONE, 64'sd2147483647, -ONE, ONE, 64'sd2147483647, ONE, -ONE,
             64'sd2147483647);
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, ONE};
    cull_on = 1'b1;
    eps_val = 16;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset ray, culling on
    directed_set();
    drain();

    // culling off, zero threshold
    set_ray(0, 0, 0, 0, 0, ONE, 1'b0, 0);
    directed_set();
    drain();

    // extreme ray and threshold
    set_ray(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
            64'sd2147483647, -64'sd2147483648, 1'b1, 65535);
    for (int i = 0; i < 20; i++) push_random();
    drain();
    set_ray(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
            -64'sd2147483648, 64'sd2147483647, 1'b0, 65535);
    for (int i = 0; i < 20; i++) push_random();
    drain();

    // random rays: mostly triangles straddling the ray, some noise
    for (int ph = 0; ph < 6; ph++) begin
      set_ray(rnd_signed(22), rnd_signed(22), rnd_signed(22), rnd_signed(19),
              rnd_signed(19), rnd_signed(19), $urandom_range(0, 1),
              (ph == 2) ? 0 : longint'($urandom_range(0, 65535)));
      no_idle = (ph == 4);
      if (ph == 3) hold_off_req = 1'b1;
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 3) != 0) push_near_ray(($urandom_range(0, 1) == 0) ? 17 : 20);
        else push_random();
      end
      drain();
    end
    no_idle = 1'b0;

    $display("covered %0d triangles in, %0d results out, %0d hits", words_in, words_out,
             hits_seen);
    $display("rays: reset, extremes and six random settings, culling on and off");
    if (errors == 0) begin
      $display("ray_triangle_intersect_unit regression: pass");
    end else begin
      $display("ray_triangle_intersect_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout at %0t", $time);
    $display("ray_triangle_intersect_unit regression: fail");
    $finish;
  end

endmodule
